/* src/d64fmt_pkg.sv */
// Shared constants, pipeline payload types and the double-dabble step function
// for the decimal64 canonical formatter. It has no dependencies.
`default_nettype none

package d64fmt_pkg;

	localparam int VALUE_W    = 64;
	localparam int DIGITS     = 20;
	localparam int BCD_W      = 4 * DIGITS;
	localparam int IDX_W      = 5;
	localparam int FD_W       = 5;
	localparam int CHAR_W     = 8;
	localparam int DAB_BITS   = 8;
	localparam int DAB_STAGES = VALUE_W / DAB_BITS;

	localparam logic [FD_W-1:0] FD_MIN = 5'd1;
	localparam logic [FD_W-1:0] FD_MAX = 5'd18;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

	// Payload of one binary-to-BCD stage.
	typedef struct packed {
		logic             neg;
		logic [FD_W-1:0]  fd;
		logic [VALUE_W-1:0] mag;
		logic [BCD_W-1:0] bcd;
	} dab_t;

	// Payload once the digit span of the text is known.
	typedef struct packed {
		logic             neg;
		logic [FD_W-1:0]  fd;
		logic [BCD_W-1:0] bcd;
		logic [IDX_W-1:0] top;
		logic [IDX_W-1:0] low;
	} digits_t;

	// Shifts DAB_BITS binary bits, most significant first, into a BCD word.
	function automatic logic [BCD_W-1:0] dab_step(input logic [BCD_W-1:0] bcd_in,
			input logic [DAB_BITS-1:0] bits);
		logic [BCD_W-1:0] acc;
		acc = bcd_in;
		for (int b = DAB_BITS - 1; b >= 0; b--) begin
			for (int d = 0; d < DIGITS; d++) begin
				if (acc[d*4 +: 4] >= 4'd5) begin
					acc[d*4 +: 4] = acc[d*4 +: 4] + 4'd3;
				end
			end
			acc = {acc[BCD_W-2:0], bits[b]};
		end
		return acc;
	endfunction

endpackage

`default_nettype wire

/* src/decimal64_canonical_formatter_core.sv */
// Top level of the decimal64 canonical formatter: sign strip, pipelined
// binary-to-BCD conversion, digit span search and the character serializer.
// Depends on d64fmt_pkg.
`default_nettype none

// Channel     Handshake                  Payload
// value       value_valid / value_stall  scaled_value[63:0], signed
// char        char_valid / char_stall    character[7:0], last_char
// config      cfg_write_en               cfg_write_data[4:0] (digits after the point)
//
// A value yields 3 to 21 characters, one per cycle on the char channel while
// char_stall is low, and holds the serializer until its last character is loaded;
// that single-character output port sets the sustained rate. The edge that accepts
// a value loads the sign stage; the eight binary-to-BCD stages of eight bits, the
// span stage, the serializer and the output register follow in that order. New
// values are taken every cycle while the stages ahead have room.
// Reset clears all valid bits and sets the fraction digit count to 1. A stall on the
// char channel backs up stage by stage; bubbles are squeezed out before the
// stall reaches value_stall.
module decimal64_canonical_formatter_core
	import d64fmt_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_write_en,
	input  wire logic [FD_W-1:0]     cfg_write_data,
	input  wire logic                value_valid,
	output logic                     value_stall,
	input  wire logic [VALUE_W-1:0]  scaled_value,
	output logic                     char_valid,
	input  wire logic                char_stall,
	output logic [CHAR_W-1:0]        character,
	output logic                     last_char
);

	// Serializer phases.
	localparam logic [1:0] PH_SIGN  = 2'd0;
	localparam logic [1:0] PH_INT   = 2'd1;
	localparam logic [1:0] PH_POINT = 2'd2;
	localparam logic [1:0] PH_FRAC  = 2'd3;

	logic [FD_W-1:0] fd_q;

	// Stage 1: sign and magnitude, with the fraction digit count clamped.
	logic             v_s1;
	logic             neg_s1;
	logic [FD_W-1:0]  fd_s1;
	logic [VALUE_W-1:0] mag_s1;

	// Stages 2 to 9 are the binary-to-BCD stages, index 0 being stage 2.
	dab_t dab_pipe_s [DAB_STAGES];
	logic [DAB_STAGES-1:0] dab_v_s;
	dab_t dab_in [DAB_STAGES];
	logic [DAB_STAGES-1:0] dab_in_v;

	// Stage 10: digit span. Stage 11: serializer.
	logic    v_s10;
	digits_t dig_s10;
	digits_t dig_next;
	logic    v_s11;
	digits_t dig_s11;
	logic [1:0]       ser_phase_q;
	logic [IDX_W-1:0] ser_idx_q;

	logic                char_valid_q;
	logic [CHAR_W-1:0]   character_q;
	logic                last_char_q;

	// Advance chain: a stage moves on when it is empty or the next one moves.
	logic [DAB_STAGES:0] dab_adv;
	logic s1_adv;
	logic s10_adv;
	logic s11_adv;
	logic out_load;

	logic [3:0]        ser_digit;
	logic [CHAR_W-1:0] cur_char;
	logic              cur_last;

	logic [FD_W-1:0] fd_clamped;

	always_comb begin
		if (fd_q < FD_MIN) begin
			fd_clamped = FD_MIN;
		end else if (fd_q > FD_MAX) begin
			fd_clamped = FD_MAX;
		end else begin
			fd_clamped = fd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fd_q <= FD_MIN;
		end else if (cfg_write_en) begin
			fd_q <= cfg_write_data;
		end
	end

	// The output register is refilled, while the serializer holds a value, whenever it is empty or being taken.
	assign out_load = v_s11 && (!char_valid_q || !char_stall);
	assign s11_adv  = !v_s11 || (out_load && cur_last);
	assign s10_adv  = !v_s10 || s11_adv;

	always_comb begin
		dab_adv[DAB_STAGES] = s10_adv;
		for (int k = DAB_STAGES - 1; k >= 0; k--) begin
			dab_adv[k] = !dab_v_s[k] || dab_adv[k+1];
		end
	end

	assign s1_adv      = !v_s1 || dab_adv[0];
	assign value_stall = !s1_adv;

	// Inputs of the BCD stages.
	always_comb begin
		dab_in[0].neg = neg_s1;
		dab_in[0].fd  = fd_s1;
		dab_in[0].mag = mag_s1;
		dab_in[0].bcd = '0;
		dab_in_v[0]   = v_s1;
		for (int k = 1; k < DAB_STAGES; k++) begin
			dab_in[k]   = dab_pipe_s[k-1];
			dab_in_v[k] = dab_v_s[k-1];
		end
	end

	// Span of the text: the highest integer digit shown and the lowest
	// fraction digit kept once trailing zeros are dropped.
	always_comb begin
		logic             hi_found;
		logic             lo_found;
		logic [IDX_W-1:0] hi_idx;
		logic [IDX_W-1:0] lo_idx;
		logic [FD_W-1:0]  fd_m1;
		dab_t             fin;
		fin      = dab_pipe_s[DAB_STAGES-1];
		hi_found = 1'b0;
		lo_found = 1'b0;
		hi_idx   = '0;
		lo_idx   = '0;
		for (int i = 0; i < DIGITS; i++) begin
			if (fin.bcd[i*4 +: 4] != 4'd0) begin
				hi_found = 1'b1;
				hi_idx   = IDX_W'(i);
			end
		end
		for (int i = DIGITS - 1; i >= 0; i--) begin
			if (fin.bcd[i*4 +: 4] != 4'd0) begin
				lo_found = 1'b1;
				lo_idx   = IDX_W'(i);
			end
		end
		fd_m1        = fin.fd - FD_MIN;
		dig_next.neg = fin.neg;
		dig_next.fd  = fin.fd;
		dig_next.bcd = fin.bcd;
		dig_next.top = (hi_found && (hi_idx > fin.fd)) ? hi_idx : fin.fd;
		dig_next.low = (lo_found && (lo_idx < fd_m1)) ? lo_idx : fd_m1;
	end

	// Character of the serializer's current position.
	assign ser_digit = dig_s11.bcd[{ser_idx_q, 2'b00} +: 4];

	always_comb begin
		cur_last = 1'b0;
		unique case (ser_phase_q)
			PH_SIGN: begin
				cur_char = CHAR_MINUS;
			end
			PH_INT: begin
				cur_char = CHAR_ZERO + {4'b0000, ser_digit};
			end
			PH_POINT: begin
				cur_char = CHAR_POINT;
			end
			default: begin
				cur_char = CHAR_ZERO + {4'b0000, ser_digit};
				cur_last = (ser_idx_q == dig_s11.low);
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			dab_v_s      <= '0;
			v_s10        <= 1'b0;
			v_s11        <= 1'b0;
			ser_phase_q  <= PH_SIGN;
			ser_idx_q    <= '0;
			char_valid_q <= 1'b0;
		end else begin
			if (s1_adv) begin
				v_s1 <= value_valid;
			end
			for (int k = 0; k < DAB_STAGES; k++) begin
				if (dab_adv[k]) begin
					dab_v_s[k] <= dab_in_v[k];
				end
			end
			if (s10_adv) begin
				v_s10 <= dab_v_s[DAB_STAGES-1];
			end
			if (s11_adv) begin
				v_s11 <= v_s10;
			end
			if (s11_adv && v_s10) begin
				ser_phase_q <= dig_s10.neg ? PH_SIGN : PH_INT;
				ser_idx_q   <= dig_s10.top;
			end else if (out_load) begin
				unique case (ser_phase_q)
					PH_SIGN: begin
						ser_phase_q <= PH_INT;
					end
					PH_INT: begin
						if (ser_idx_q == dig_s11.fd) begin
							ser_phase_q <= PH_POINT;
						end else begin
							ser_idx_q <= ser_idx_q - 1'b1;
						end
					end
					PH_POINT: begin
						ser_phase_q <= PH_FRAC;
						ser_idx_q   <= dig_s11.fd - FD_MIN;
					end
					default: begin
						ser_idx_q <= ser_idx_q - 1'b1;
					end
				endcase
			end
			if (out_load) begin
				char_valid_q <= 1'b1;
			end else if (!char_stall) begin
				char_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s1_adv && value_valid) begin
			neg_s1 <= scaled_value[VALUE_W-1];
			fd_s1  <= fd_clamped;
			mag_s1 <= scaled_value[VALUE_W-1] ? (~scaled_value + 1'b1) : scaled_value;
		end
		for (int k = 0; k < DAB_STAGES; k++) begin
			if (dab_adv[k] && dab_in_v[k]) begin
				dab_pipe_s[k].neg <= dab_in[k].neg;
				dab_pipe_s[k].fd  <= dab_in[k].fd;
				dab_pipe_s[k].mag <= dab_in[k].mag << DAB_BITS;
				dab_pipe_s[k].bcd <= dab_step(dab_in[k].bcd,
						dab_in[k].mag[VALUE_W-1 -: DAB_BITS]);
			end
		end
		if (s10_adv && dab_v_s[DAB_STAGES-1]) begin
			dig_s10 <= dig_next;
		end
		if (s11_adv && v_s10) begin
			dig_s11 <= dig_s10;
		end
		if (out_load) begin
			character_q <= cur_char;
			last_char_q <= cur_last;
		end
	end

	assign char_valid = char_valid_q;
	assign character  = character_q;
	assign last_char  = last_char_q;

endmodule

`default_nettype wire

/* tb/d64fmt_text_checker.sv */
// Checker for the decimal64 canonical formatter: watches the value, config and char
// channels, predicts the text of each value and compares it character by character.
// Depends on d64fmt_pkg.
`default_nettype none

module d64fmt_text_checker
	import d64fmt_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_write_en,
	input  wire logic [FD_W-1:0]     cfg_write_data,
	input  wire logic                value_valid,
	input  wire logic                value_stall,
	input  wire logic [VALUE_W-1:0]  scaled_value,
	input  wire logic                char_valid,
	input  wire logic                char_stall,
	input  wire logic [CHAR_W-1:0]   character,
	input  wire logic                last_char,
	output int                       fail_count,
	output int                       pending_chars
);

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} text_char_t;

	text_char_t      expected_text[$];
	logic [FD_W-1:0] frac_len;

	// Appends the canonical text of one value, as the block must emit it.
	function automatic void queue_expected_text(input logic [VALUE_W-1:0] value,
			input logic [FD_W-1:0] fd_reg);
		logic [3:0]         digit [DIGITS];
		logic [VALUE_W-1:0] mag;
		logic [CHAR_W-1:0]  text [$];
		text_char_t         tc;
		int                 fd;
		int                 n;
		int                 s;
		fd = (fd_reg < FD_MIN) ? FD_MIN : (fd_reg > FD_MAX) ? FD_MAX : fd_reg;
		mag = value[VALUE_W-1] ? -value : value;
		n = 0;
		while (mag != 0 && n < DIGITS) begin
			digit[n] = 4'(mag % 10);
			mag = mag / 10;
			n++;
		end
		while (n < fd + 1) begin
			digit[n] = 4'd0;
			n++;
		end
		// Trailing fraction zeros go, but one fraction digit always stays.
		s = 0;
		while (s < fd - 1 && digit[s] == 4'd0)
			s++;
		if (value[VALUE_W-1])
			text.push_back(CHAR_MINUS);
		for (int i = n; i > fd; i--)
			text.push_back(CHAR_ZERO + digit[i-1]);
		text.push_back(CHAR_POINT);
		for (int i = fd; i > s; i--)
			text.push_back(CHAR_ZERO + digit[i-1]);
		foreach (text[i]) begin
			tc.code = text[i];
			tc.last = (i == text.size() - 1);
			expected_text.push_back(tc);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		text_char_t want;
		if (!arst_n) begin
			frac_len = FD_MIN;
			expected_text.delete();
			fail_count = 0;
		end else begin
			if (value_valid && !value_stall)
				queue_expected_text(scaled_value, frac_len);
			if (cfg_write_en)
				frac_len = cfg_write_data;
			if (char_valid && !char_stall) begin
				if (expected_text.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("char %h last %b arrived with nothing expected",
							character, last_char);
				end else begin
					want = expected_text.pop_front();
					if (character !== want.code || last_char !== want.last) begin
						fail_count++;
						if (fail_count <= 10)
							$display("char mismatch: expected %h last %b, got %h last %b",
								want.code, want.last, character, last_char);
					end
				end
			end
		end
		pending_chars = expected_text.size();
	end

endmodule

`default_nettype wire

/* tb/decimal64_canonical_formatter_core_tb.sv */
// Top of the decimal64 canonical formatter testbench: clock, reset, value and config
// stimulus, char stall pattern and the verdict. Depends on d64fmt_pkg, the core and
// d64fmt_text_checker.
`default_nettype none

module decimal64_canonical_formatter_core_tb;
	import d64fmt_pkg::*;

	// The slowest correct run is roughly 400 values of 21 characters each, with the
	// receiver stalling most cycles plus one long hold; the limit is many times that.
	localparam int CYCLE_LIMIT      = 400000;
	// A little more than the latency of an empty pipeline.
	localparam int SETTLE_CYCLES    = 20;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int PHASE_VALUES     = 46;

	localparam logic [VALUE_W-1:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [VALUE_W-1:0] VALUE_MIN = 64'h8000_0000_0000_0000;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_write_en = 1'b0;
	logic [FD_W-1:0]     cfg_write_data = '0;
	logic                value_valid = 1'b0;
	logic [VALUE_W-1:0]  scaled_value = '0;
	logic                char_stall = 1'b0;
	wire logic           value_stall;
	wire logic           char_valid;
	wire logic [CHAR_W-1:0] character;
	wire logic           last_char;

	int fail_count;
	int pending_chars;

	// Set by the stimulus process to ask the receiver for one long hold-off.
	bit long_hold_req = 1'b0;
	// Transactions left in the current sender burst.
	int burst_left = 0;

	always #1 clk = ~clk;

	decimal64_canonical_formatter_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.value_valid    (value_valid),
		.value_stall    (value_stall),
		.scaled_value   (scaled_value),
		.char_valid     (char_valid),
		.char_stall     (char_stall),
		.character      (character),
		.last_char      (last_char)
	);

	d64fmt_text_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.value_valid    (value_valid),
		.value_stall    (value_stall),
		.scaled_value   (scaled_value),
		.char_valid     (char_valid),
		.char_stall     (char_stall),
		.character      (character),
		.last_char      (last_char),
		.fail_count     (fail_count),
		.pending_chars  (pending_chars)
	);

	// Ten to the power k, for building values with known trailing zeros.
	function automatic logic [VALUE_W-1:0] pow10(input int k);
		logic [VALUE_W-1:0] p;
		p = 1;
		for (int i = 0; i < k; i++)
			p = p * 10;
		return p;
	endfunction

	// Random value drawn from several families so that short texts, long texts,
	// stripped fractions and the extremes of the range all show up often.
	function automatic logic [VALUE_W-1:0] random_value(input logic [FD_W-1:0] fd_reg);
		logic [VALUE_W-1:0] v;
		int                 fd;
		fd = (fd_reg < FD_MIN) ? FD_MIN : (fd_reg > FD_MAX) ? FD_MAX : fd_reg;
		case ($urandom_range(0, 5))
			0: v = {$urandom, $urandom};
			1: v = $urandom_range(0, 2000);
			2: v = $urandom_range(1, 99999) * pow10($urandom_range(0, 14));
			3: begin
				case ($urandom_range(0, 3))
					0: v = VALUE_MAX;
					1: v = VALUE_MIN;
					2: v = VALUE_MAX - $urandom_range(0, 1000);
					default: v = VALUE_MIN + $urandom_range(0, 1000);
				endcase
			end
			// Values smaller than one unit give a bare "0." integer part.
			4: v = {$urandom, $urandom} % pow10(fd);
			// Whole numbers give a single "0" fraction digit.
			default: v = $urandom_range(0, 100000) * pow10(fd);
		endcase
		if ($urandom_range(0, 1) && v != VALUE_MIN)
			v = -v;
		return v;
	endfunction

	// Offers one value and returns right after the edge that accepts it. Between
	// bursts the sender drops valid for a random gap; some bursts follow each
	// other with no gap at all.
	task automatic offer_value(input logic [VALUE_W-1:0] v);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				value_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		value_valid <= 1'b1;
		scaled_value <= v;
		// Stall is steady from the falling edge to the next rising edge, so a low
		// stall seen here means the transaction completes on that rising edge.
		do
			@(negedge clk);
		while (value_stall);
		@(posedge clk);
	endtask

	// Stops offering and waits until every expected character has come out,
	// then lets the pipeline settle.
	task automatic drain_block();
		value_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_chars != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the fraction digit count while the block is idle.
	task automatic set_frac_len(input logic [FD_W-1:0] fd);
		drain_block();
		cfg_write_en <= 1'b1;
		cfg_write_data <= fd;
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	// Receiver: the stall pattern switches at random moments among the modes of no
	// stall, light random stall, heavy random stall and strict alternation. On
	// request it holds stall high for a long stretch that it counts itself.
	initial begin : char_receiver
		int hold_left;
		int mode;
		int mode_left;
		hold_left = 0;
		mode = 0;
		mode_left = 0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				char_stall <= 1'b1;
			end else begin
				case (mode)
					0: char_stall <= 1'b0;
					1: char_stall <= ($urandom_range(0, 3) == 0);
					2: char_stall <= ($urandom_range(0, 9) < 7);
					default: char_stall <= ~char_stall;
				endcase
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		logic [FD_W-1:0] fd_plan [8];
		// Driven late in the first time step so every reset process sees the edge.
		arst_n <= 1'b0;
		fd_plan[0] = 5'd2;
		fd_plan[1] = 5'd18;
		fd_plan[2] = 5'd0;
		fd_plan[3] = 5'd9;
		fd_plan[4] = 5'd31;
		fd_plan[5] = 5'd1;
		fd_plan[6] = 5'd17;
		fd_plan[7] = 5'($urandom_range(0, 31));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset setting of one fraction digit: zero, unit
		// steps, a stripped fraction, and both ends of the range including the
		// most negative value whose magnitude only fits as unsigned.
		offer_value(64'd0);
		offer_value(64'd1);
		offer_value(-64'd1);
		offer_value(64'd10);
		offer_value(-64'd10);
		offer_value(VALUE_MAX);
		offer_value(VALUE_MIN);
		offer_value(64'd123450);

		// A zero setting saturates to one fraction digit.
		set_frac_len(5'd0);
		offer_value(64'd25);
		offer_value(-64'd7);

		// Widest setting: everything but the top digit sits behind the point.
		set_frac_len(FD_MAX);
		offer_value(64'd0);
		offer_value(VALUE_MIN);
		offer_value(VALUE_MAX);
		offer_value(pow10(18));
		offer_value(-64'd1);
		offer_value(5 * pow10(17));

		// Settings above eighteen saturate to eighteen.
		set_frac_len(5'd31);
		offer_value(64'd1);
		offer_value(5 * pow10(18));

		// Random phases, one setting each. In the third phase the receiver holds
		// off for a long stretch while the sender keeps offering, so the pipeline
		// fills and backs up into value_stall. Every phase ends with a full drain.
		foreach (fd_plan[p]) begin
			set_frac_len(fd_plan[p]);
			if (p == 2)
				long_hold_req = 1'b1;
			repeat (PHASE_VALUES)
				offer_value(random_value(fd_plan[p]));
		end

		drain_block();
		if (fail_count == 0 && pending_chars == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
